[src/lpfs_pkg.sv]
// Shared types and constants for the lidar point filter and statistics block.
// No dependencies; every other file imports this package.
package lpfs_pkg;

   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int RET_CLASSES   = 7;
   localparam int MODE_BIT_LAST  = 0;
   localparam int MODE_BIT_FIRST = 1;
   localparam int MODE_BIT_CLIP  = 2;
   localparam logic [2:0] RET_FIRST = 3'd1;

   typedef enum logic [2:0] {
      CSR_FILTER_MODE,
      CSR_CLIP_X_MIN,
      CSR_CLIP_Y_MIN,
      CSR_CLIP_X_MAX,
      CSR_CLIP_Y_MAX,
      CSR_RETURN_DROP_MASK,
      CSR_SCAN_ANGLE_LIMIT,
      CSR_INTENSITY_MIN
   } csr_index_type;

   typedef enum logic [2:0] {
      REASON_NONE,
      REASON_NOT_LAST,
      REASON_NOT_FIRST,
      REASON_CLIPPED,
      REASON_RETURN_MASK,
      REASON_ANGLE,
      REASON_INTENSITY
   } drop_reason_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        intensity;
      logic [2:0]         return_index;
      logic [2:0]         returns_in_pulse;
      logic signed [7:0]  scan_angle;
   } lpfs_req_type;

   typedef struct packed {
      logic               keep;
      logic [2:0]         drop_reason;
      logic [31:0]        survivor_total;
      logic [31:0]        return_class_total;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_z;
   } lpfs_rsp_type;

   typedef struct packed {
      logic [2:0]         filter_mode;
      logic signed [31:0] clip_x_min;
      logic signed [31:0] clip_y_min;
      logic signed [31:0] clip_x_max;
      logic signed [31:0] clip_y_max;
      logic [7:0]         return_drop_mask;
      logic [6:0]         scan_angle_limit;
      logic [15:0]        intensity_min;
   } lpfs_cfg_type;

   typedef struct packed {
      logic               keep;
      drop_reason_type    drop_reason;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [2:0]         return_index;
   } lpfs_item_type;

endpackage

[src/lidar_point_filter_stats_core.sv]
// Top level of the lidar point filter and survivor statistics block.
// Depends on lpfs_pkg, lpfs_csr, lpfs_classify, lpfs_queue and lpfs_stats.
//
// Usage:
//   req_*  : one lidar point per request (valid/ready). The filter chain tags it
//            as it enters and pushes it into a short queue.
//   rsp_*  : one result per request, in order (valid/ready): keep flag, first
//            failing reason, survivor counts and the survivor bounding box.
//   csr_*  : APB-style register port, 4-byte stride, pready tied high. Write
//            registers only while no request is in flight.
// Path: an accepted request is written into a queue slot, then the result
//   register is updated with the statistics when that slot pops.
// Throughput: one point per cycle while rsp_ready stays high; the statistics
//   update at queue pop is the loop that sets this rate.
// Stall: while rsp_ready is low the result register holds, the queue fills,
//   then req_ready drops; it rises again the cycle after a result is taken
//   and the queue pops.
// Reset: synchronous; clears config registers, counters, bounding box and queue.
module lidar_point_filter_stats_core
   import lpfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lpfs_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lpfs_rsp_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   lpfs_cfg_type  cfg;
   lpfs_item_type front_item;
   lpfs_item_type head_item;
   logic          queue_full;
   logic          queue_valid;
   logic          queue_pop;

   assign req_ready = ~queue_full;

   lpfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lpfs_classify u_classify (
      .cfg  (cfg),
      .req  (req_data),
      .item (front_item)
   );

   lpfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .head      (head_item)
   );

   lpfs_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (head_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[src/lpfs_csr.sv]
// Configuration register file behind the APB-style port.
// Depends on lpfs_pkg for the register index codes and the config struct.
module lpfs_csr
   import lpfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output lpfs_cfg_type          cfg
);

   lpfs_cfg_type  cfg_ff;
   lpfs_cfg_type  cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index    = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_FILTER_MODE:      cfg_in.filter_mode      = pwdata[2:0];
            CSR_CLIP_X_MIN:       cfg_in.clip_x_min       = $signed(pwdata);
            CSR_CLIP_Y_MIN:       cfg_in.clip_y_min       = $signed(pwdata);
            CSR_CLIP_X_MAX:       cfg_in.clip_x_max       = $signed(pwdata);
            CSR_CLIP_Y_MAX:       cfg_in.clip_y_max       = $signed(pwdata);
            CSR_RETURN_DROP_MASK: cfg_in.return_drop_mask = pwdata[7:0];
            CSR_SCAN_ANGLE_LIMIT: cfg_in.scan_angle_limit = pwdata[6:0];
            CSR_INTENSITY_MIN:    cfg_in.intensity_min    = pwdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_FILTER_MODE:      prdata = {29'd0, cfg_ff.filter_mode};
         CSR_CLIP_X_MIN:       prdata = cfg_ff.clip_x_min;
         CSR_CLIP_Y_MIN:       prdata = cfg_ff.clip_y_min;
         CSR_CLIP_X_MAX:       prdata = cfg_ff.clip_x_max;
         CSR_CLIP_Y_MAX:       prdata = cfg_ff.clip_y_max;
         CSR_RETURN_DROP_MASK: prdata = {24'd0, cfg_ff.return_drop_mask};
         CSR_SCAN_ANGLE_LIMIT: prdata = {25'd0, cfg_ff.scan_angle_limit};
         CSR_INTENSITY_MIN:    prdata = {16'd0, cfg_ff.intensity_min};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/lpfs_classify.sv]
// Front end: runs one point through the ordered filter chain and tags it.
// Depends on lpfs_pkg for the request, config and queue item types.
module lpfs_classify
   import lpfs_pkg::*;
(
   input  lpfs_cfg_type  cfg,
   input  lpfs_req_type  req,
   output lpfs_item_type item
);

   drop_reason_type    reason;
   logic               clip_out;
   logic signed [8:0]  angle;
   logic signed [8:0]  limit;
   logic               angle_out;

   assign clip_out = (req.pos_x < cfg.clip_x_min) || (req.pos_y < cfg.clip_y_min) ||
                     (req.pos_x > cfg.clip_x_max) || (req.pos_y > cfg.clip_y_max);

   assign angle     = 9'(req.scan_angle);
   assign limit     = $signed({2'b00, cfg.scan_angle_limit});
   assign angle_out = (angle > limit) || (angle < -limit);

   always_comb begin
      if (cfg.filter_mode[MODE_BIT_LAST] && req.return_index != req.returns_in_pulse) begin
         reason = REASON_NOT_LAST;
      end else if (cfg.filter_mode[MODE_BIT_FIRST] && req.return_index != RET_FIRST) begin
         reason = REASON_NOT_FIRST;
      end else if (cfg.filter_mode[MODE_BIT_CLIP] && clip_out) begin
         reason = REASON_CLIPPED;
      end else if (cfg.return_drop_mask[req.return_index]) begin
         reason = REASON_RETURN_MASK;
      end else if (cfg.scan_angle_limit != '0 && angle_out) begin
         reason = REASON_ANGLE;
      end else if (cfg.intensity_min != '0 && req.intensity < cfg.intensity_min) begin
         reason = REASON_INTENSITY;
      end else begin
         reason = REASON_NONE;
      end
   end

   always_comb begin
      item.keep         = (reason == REASON_NONE);
      item.drop_reason  = reason;
      item.pos_x        = req.pos_x;
      item.pos_y        = req.pos_y;
      item.pos_z        = req.pos_z;
      item.return_index = req.return_index;
   end

endmodule

[src/lpfs_queue.sv]
// Short FIFO of classified points between the filter front end and stats back end.
// Depends on lpfs_pkg for the queue item type.
module lpfs_queue
   import lpfs_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  lpfs_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output lpfs_item_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lpfs_item_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/lpfs_stats.sv]
// Back end: updates survivor counters and the bounding box, holds the result register.
// Depends on lpfs_pkg for the queue item and result types.
module lpfs_stats
   import lpfs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  lpfs_item_type item,
   output logic          item_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output lpfs_rsp_type  rsp_data
);

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == '1) ? v : v + 32'd1;
   endfunction

   logic               rsp_valid_ff, rsp_valid_in;
   lpfs_rsp_type       rsp_data_ff, rsp_data_in;
   logic               box_empty_ff, box_empty_in;
   logic [31:0]        survivor_ff, survivor_in;
   logic [31:0]        class_count_ff [RET_CLASSES];
   logic [31:0]        class_count_in;
   logic signed [31:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [31:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic signed [31:0] min_z_ff, min_z_in, max_z_ff, max_z_in;
   logic [2:0]         class_idx;
   logic               has_class;
   logic [31:0]        class_cur;
   logic               take;

   assign item_pop  = item_valid & (~rsp_valid_ff | rsp_ready);
   assign take      = item_pop & item.keep;
   assign has_class = (item.return_index != '0);
   assign class_idx = item.return_index - 3'd1;
   assign class_cur = has_class ? class_count_ff[class_idx] : '0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      box_empty_in   = box_empty_ff;
      survivor_in    = survivor_ff;
      class_count_in = class_cur;
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      min_z_in = min_z_ff;
      max_z_in = max_z_ff;
      if (take) begin
         survivor_in  = sat_inc(survivor_ff);
         box_empty_in = 1'b0;
         if (has_class) begin
            class_count_in = sat_inc(class_cur);
         end
         if (box_empty_ff) begin
            min_x_in = item.pos_x;
            max_x_in = item.pos_x;
            min_y_in = item.pos_y;
            max_y_in = item.pos_y;
            min_z_in = item.pos_z;
            max_z_in = item.pos_z;
         end else begin
            min_x_in = (item.pos_x < min_x_ff) ? item.pos_x : min_x_ff;
            max_x_in = (item.pos_x > max_x_ff) ? item.pos_x : max_x_ff;
            min_y_in = (item.pos_y < min_y_ff) ? item.pos_y : min_y_ff;
            max_y_in = (item.pos_y > max_y_ff) ? item.pos_y : max_y_ff;
            min_z_in = (item.pos_z < min_z_ff) ? item.pos_z : min_z_ff;
            max_z_in = (item.pos_z > max_z_ff) ? item.pos_z : max_z_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (item_pop) begin
         rsp_valid_in                   = 1'b1;
         rsp_data_in.keep               = item.keep;
         rsp_data_in.drop_reason        = item.drop_reason;
         rsp_data_in.survivor_total     = survivor_in;
         rsp_data_in.return_class_total = class_count_in;
         rsp_data_in.box_min_x          = min_x_in;
         rsp_data_in.box_max_x          = max_x_in;
         rsp_data_in.box_min_y          = min_y_in;
         rsp_data_in.box_max_y          = max_y_in;
         rsp_data_in.box_min_z          = min_z_in;
         rsp_data_in.box_max_z          = max_z_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         box_empty_ff <= 1'b1;
         survivor_ff  <= '0;
         min_x_ff     <= '0;
         max_x_ff     <= '0;
         min_y_ff     <= '0;
         max_y_ff     <= '0;
         min_z_ff     <= '0;
         max_z_ff     <= '0;
         for (int i = 0; i < RET_CLASSES; i++) begin
            class_count_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         box_empty_ff <= box_empty_in;
         survivor_ff  <= survivor_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         min_z_ff     <= min_z_in;
         max_z_ff     <= max_z_in;
         if (take && has_class) begin
            class_count_ff[class_idx] <= class_count_in;
         end
      end
   end

endmodule

[src/lpfs_checker.sv]
// Port-level checks for lidar_point_filter_stats_core, attached by bind.
// Depends on lpfs_pkg for the result type and drop reason codes.
module lpfs_checker
   import lpfs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input lpfs_rsp_type          rsp_data
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.keep == (rsp_data.drop_reason == REASON_NONE)))
      else $error("keep flag disagrees with drop reason");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.keep |-> rsp_data.survivor_total != 32'd0)
      else $error("kept point with zero survivor total");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.survivor_total != 32'd0 |->
         rsp_data.box_min_x <= rsp_data.box_max_x &&
         rsp_data.box_min_y <= rsp_data.box_max_y &&
         rsp_data.box_min_z <= rsp_data.box_max_z)
      else $error("bounding box inverted");

endmodule

bind lidar_point_filter_stats_core lpfs_checker u_lpfs_checker (.*);
